[design/assert_macros.svh]
// Assertion helpers used by escape_sequence_decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising clock edge outside reset.
`define ESD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that cond implies prop in the same cycle.
`define ESD_ASSERT_IMPL(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

`endif

[design/esd_pkg.sv]
`timescale 1ns / 1ps

package esd_pkg;

   localparam int OCT_DIGITS_DEF = 3;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_NO_HEX   = 2'd1;
   localparam logic [1:0] ERR_NO_OCT   = 2'd2;
   localparam logic [1:0] ERR_DANGLING = 2'd3;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_X         = 8'h78;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESC    = 2'd1,
      MODE_HEX    = 2'd2,
      MODE_OCT    = 2'd3
   } mode_type;

   typedef struct packed {
      logic [31:0] code;
      logic [1:0]  error_kind;
      logic [15:0] codes_so_far;
      logic        end_of_literal;
   } result_type;

   // Results produced by one accepted byte: r0 first, r1 only when count is two.
   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } push_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   typedef struct packed {
      logic       valid;
      logic [6:0] value;
   } named_type;

   function automatic hex_digit_type hex_value(input logic [7:0] c);
      hex_digit_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         h.value = 4'(c[2:0] + 3'd1) + 4'd8;
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

   function automatic named_type named_escape(input logic [7:0] c);
      named_type n;
      n.valid = 1'b1;
      case (c)
         8'h61:   n.value = 7'd7;
         8'h62:   n.value = 7'd8;
         8'h66:   n.value = 7'd12;
         8'h6E:   n.value = 7'd10;
         8'h72:   n.value = 7'd13;
         8'h74:   n.value = 7'd9;
         8'h76:   n.value = 7'd11;
         8'h5C:   n.value = 7'h5C;
         8'h3F:   n.value = 7'h3F;
         8'h27:   n.value = 7'h27;
         8'h22:   n.value = 7'h22;
         default: begin
            n.valid = 1'b0;
            n.value = 7'd0;
         end
      endcase
      return n;
   endfunction

   function automatic result_type mk_res(input logic [31:0] code, input logic [1:0] err,
                                         input logic eol);
      result_type r;
      r.code           = code;
      r.error_kind     = err;
      r.codes_so_far   = 16'd0;
      r.end_of_literal = eol;
      return r;
   endfunction

endpackage

[design/esd_core.sv]
`timescale 1ns / 1ps

module esd_core import esd_pkg::*; #(
   parameter int OctalDigits = OCT_DIGITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] ch,
   input  logic       is_last,
   input  logic       csr_fire,
   input  logic       csr_value,
   output push_type   push
);

   mode_type    mode_ff, mode_in;
   logic [31:0] pend_ff, pend_in;
   logic [1:0]  dcnt_ff, dcnt_in;
   logic [15:0] cnt_ff, cnt_in;
   logic        signed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         pend_ff   <= '0;
         dcnt_ff   <= '0;
         cnt_ff    <= '0;
         signed_ff <= 1'b1;
      end else begin
         if (fire) begin
            mode_ff <= mode_in;
            pend_ff <= pend_in;
            dcnt_ff <= dcnt_in;
            cnt_ff  <= cnt_in;
         end
         if (csr_fire) begin
            signed_ff <= csr_value;
         end
      end
   end

   always_comb begin
      hex_digit_type hx;
      named_type     nm;
      logic          is_oct;
      logic          is_bs;
      logic          plain_emit;
      result_type    plain;
      logic          has_pre, has_main;
      result_type    pre, main;
      logic [15:0]   c1, c2;

      hx     = hex_value(ch);
      nm     = named_escape(ch);
      is_oct = (ch >= 8'h30) && (ch <= 8'h37);
      is_bs  = (ch == CH_BACKSLASH);

      // A backslash either dangles at the end or opens an escape.
      plain_emit = !is_bs || is_last;
      if (is_bs) begin
         plain = mk_res(32'd0, ERR_DANGLING, 1'b1);
      end else if (signed_ff && ch[7]) begin
         plain = mk_res({24'hFFFFFF, ch}, ERR_NONE, is_last);
      end else begin
         plain = mk_res({24'd0, ch}, ERR_NONE, is_last);
      end

      mode_in  = mode_ff;
      pend_in  = pend_ff;
      dcnt_in  = dcnt_ff;
      has_pre  = 1'b0;
      has_main = 1'b0;
      pre      = mk_res(32'd0, ERR_NONE, 1'b0);
      main     = plain;

      unique case (mode_ff)
         MODE_NORMAL: begin
            has_main = plain_emit;
            if (!plain_emit) begin
               mode_in = MODE_ESC;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_NORMAL;
            if (nm.valid) begin
               has_main = 1'b1;
               main     = mk_res({25'd0, nm.value}, ERR_NONE, is_last);
            end else if (ch == CH_X) begin
               if (is_last) begin
                  has_main = 1'b1;
                  main     = mk_res(32'd0, ERR_NO_HEX, 1'b1);
               end else begin
                  mode_in = MODE_HEX;
                  pend_in = '0;
                  dcnt_in = '0;
               end
            end else if (is_oct) begin
               pend_in = {29'd0, ch[2:0]};
               dcnt_in = 2'd1;
               if (OctalDigits <= 1 || is_last) begin
                  has_main = 1'b1;
                  main     = mk_res(pend_in, ERR_NONE, is_last);
               end else begin
                  mode_in = MODE_OCT;
               end
            end else begin
               has_pre  = 1'b1;
               pre      = mk_res(32'd0, ERR_NO_OCT, 1'b0);
               has_main = plain_emit;
               if (!plain_emit) begin
                  mode_in = MODE_ESC;
               end
            end
         end
         MODE_HEX: begin
            if (hx.valid) begin
               pend_in = {pend_ff[27:0], hx.value};
               dcnt_in = 2'd1;
               if (is_last) begin
                  mode_in  = MODE_NORMAL;
                  has_main = 1'b1;
                  main     = mk_res(pend_in, ERR_NONE, 1'b1);
               end
            end else begin
               // The terminator flushes the hex value, or reports a missing hex digit, and is then decoded itself.
               mode_in = MODE_NORMAL;
               has_pre = 1'b1;
               if (dcnt_ff != 2'd0) begin
                  pre = mk_res(pend_ff, ERR_NONE, 1'b0);
               end else begin
                  pre = mk_res(32'd0, ERR_NO_HEX, 1'b0);
               end
               has_main = plain_emit;
               if (!plain_emit) begin
                  mode_in = MODE_ESC;
               end
            end
         end
         MODE_OCT: begin
            if (is_oct && (dcnt_ff < 2'(OctalDigits))) begin
               pend_in = {pend_ff[28:0], ch[2:0]};
               dcnt_in = dcnt_ff + 2'd1;
               if ((dcnt_in >= 2'(OctalDigits)) || is_last) begin
                  mode_in  = MODE_NORMAL;
                  has_main = 1'b1;
                  main     = mk_res(pend_in, ERR_NONE, is_last);
               end
            end else begin
               mode_in  = MODE_NORMAL;
               has_pre  = 1'b1;
               pre      = mk_res(pend_ff, ERR_NONE, 1'b0);
               has_main = plain_emit;
               if (!plain_emit) begin
                  mode_in = MODE_ESC;
               end
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
         end
      endcase

      c1 = (cnt_ff == 16'hFFFF) ? cnt_ff : cnt_ff + 16'd1;
      c2 = (c1 == 16'hFFFF) ? c1 : c1 + 16'd1;

      push.count           = {1'b0, has_pre} + {1'b0, has_main};
      push.r0              = has_pre ? pre : main;
      push.r0.codes_so_far = c1;
      push.r1              = main;
      push.r1.codes_so_far = c2;

      if (push.count == 2'd2) begin
         cnt_in = c2;
      end else if (push.count == 2'd1) begin
         cnt_in = c1;
      end else begin
         cnt_in = cnt_ff;
      end

      if (is_last) begin
         mode_in = MODE_NORMAL;
         pend_in = '0;
         dcnt_in = '0;
         cnt_in  = '0;
      end
   end

endmodule

[design/esd_queue.sv]
`timescale 1ns / 1ps

module esd_queue import esd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_en,
   input  push_type          push,
   output logic              room,
   output logic [QLVL_W-1:0] level,
   output logic              out_valid,
   input  logic              out_ready,
   output result_type        out_item
);

   result_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] head_ff, head_in;
   logic [QLVL_W-1:0] level_ff, level_in;
   logic [QPTR_W-1:0] tail0, tail1;
   logic [1:0]        n_push;
   logic              pop;

   assign out_valid = (level_ff != '0);
   assign out_item  = slot_ff[head_ff];
   assign level     = level_ff;
   // Room for the two results that one byte can produce.
   assign room      = (level_ff < QLVL_W'(QUEUE_DEPTH - 1));
   assign pop       = out_valid && out_ready;
   assign n_push    = push_en ? push.count : 2'd0;
   assign tail0     = head_ff + QPTR_W'(level_ff);
   assign tail1     = tail0 + QPTR_W'(1);

   always_comb begin
      head_in  = pop ? head_ff + QPTR_W'(1) : head_ff;
      level_in = level_ff + QLVL_W'(n_push) - QLVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         level_ff <= '0;
      end else begin
         head_ff  <= head_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         slot_ff[tail0] <= push.r0;
      end
      if (n_push == 2'd2) begin
         slot_ff[tail1] <= push.r1;
      end
   end

endmodule

[design/escape_sequence_decoder.sv]
`timescale 1ns / 1ps
// Channel  Direction  Payload
// req      in         tdata[7:0] ch, tlast is_last
// rsp      out        tdata[31:0] code, tdata[47:32] codes_so_far,
//                     tuser[1:0] error_kind, tlast end_of_literal
// csr      in         wdata plain_char_signed
//
// One byte is accepted per cycle while the queue has room; its results are written into the queue at the transfer.
// A byte that terminates a hex or octal escape, or that follows a backslash without
// forming an escape, can yield two results; the four-entry result queue absorbs this,
// and a byte is accepted whenever at least two entries are free.
// Reset clears the decode state and the queue and sets plain_char_signed to 1.
// A stall on rsp fills the queue; req_tready then drops until space returns.

`include "assert_macros.svh"

module escape_sequence_decoder import esd_pkg::*; #(
   parameter int OCTAL_DIGITS = OCT_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // ch
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // code [31:0], codes_so_far [47:32]
   output logic [1:0]  rsp_tuser,   // error_kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_wdata
);

   push_type          push;
   result_type        item;
   logic              room;
   logic [QLVL_W-1:0] level;
   logic              req_fire;

   assign req_tready = room;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   esd_core #(
      .OctalDigits(OCTAL_DIGITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (req_fire),
      .ch        (req_tdata),
      .is_last   (req_tlast),
      .csr_fire  (csr_valid && csr_ready),
      .csr_value (csr_wdata),
      .push      (push)
   );

   esd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (req_fire),
      .push      (push),
      .room      (room),
      .level     (level),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (item)
   );

   assign rsp_tdata = {item.codes_so_far, item.code};
   assign rsp_tuser = item.error_kind;
   assign rsp_tlast = item.end_of_literal;

   `ESD_ASSERT(a_level_bound, level <= QLVL_W'(QUEUE_DEPTH), "result queue overflow")
   `ESD_ASSERT_IMPL(a_err_zero, rsp_tvalid && rsp_tuser != ERR_NONE, rsp_tdata[31:0] == 32'd0, "error result with nonzero code")
   `ESD_ASSERT_IMPL(a_dangling_last, rsp_tvalid && rsp_tuser == ERR_DANGLING, rsp_tlast, "dangling backslash not at end of literal")
   `ESD_ASSERT_IMPL(a_count_nonzero, rsp_tvalid, rsp_tdata[47:32] != 16'd0, "result with zero code count")

endmodule
